// ===== hw/rtl/tpdu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpdu_pkg
// Shared types and constants for the TPKT / transport data TPDU deframer.
// ----------------------------------------------------------------------------
package tpdu_pkg;

    // header byte values
    localparam logic [7:0] TPKT_VERSION  = 8'h03;
    localparam logic [7:0] TPKT_RESERVED = 8'h00;
    localparam logic [7:0] CODE_DT       = 8'hF0;
    localparam logic [7:0] CODE_DR       = 8'h80;
    localparam logic [7:0] CODE_ER       = 8'h70;
    localparam logic [7:0] EOT_CLEAR     = 8'h00;
    localparam logic [7:0] EOT_SET       = 8'h80;
    localparam logic [7:0] LI_DT         = 8'd2;
    localparam logic [7:0] LI_DR         = 8'd6;
    localparam logic [7:0] REASON_MAX    = 8'd4;
    localparam logic [15:0] HEADER_LEN   = 16'd7;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DISC  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_VERSION  = 4'd1;
    localparam logic [3:0] ERR_RESERVED = 4'd2;
    localparam logic [3:0] ERR_SHORT    = 4'd3;
    localparam logic [3:0] ERR_LI       = 4'd4;
    localparam logic [3:0] ERR_EOT      = 4'd5;
    localparam logic [3:0] ERR_SRC_REF  = 4'd6;
    localparam logic [3:0] ERR_DST_REF  = 4'd7;
    localparam logic [3:0] ERR_REASON   = 4'd8;
    localparam logic [3:0] ERR_ER_TPDU  = 4'd9;
    localparam logic [3:0] ERR_UNKNOWN  = 4'd10;

    // configuration register indexes
    localparam logic CFG_LOCAL_REF  = 1'b0;
    localparam logic CFG_REMOTE_REF = 1'b1;

    // parser phase, one-hot
    typedef enum logic [12:0] {
        PH_VER    = 13'b0000000000001,
        PH_RSV    = 13'b0000000000010,
        PH_LENHI  = 13'b0000000000100,
        PH_LENLO  = 13'b0000000001000,
        PH_LI     = 13'b0000000010000,
        PH_CODE   = 13'b0000000100000,
        PH_EOT    = 13'b0000001000000,
        PH_DATA   = 13'b0000010000000,
        PH_R1HI   = 13'b0000100000000,
        PH_R1LO   = 13'b0001000000000,
        PH_R2HI   = 13'b0010000000000,
        PH_R2LO   = 13'b0100000000000,
        PH_REASON = 13'b1000000000000
    } tpdu_phase_t;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last;
        logic [3:0] error_code;
    } tpdu_result_t;

endpackage

// ===== hw/rtl/transport_data_tpdu_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transport_data_tpdu_deframer
// TPKT / transport data TPDU deframer: checks headers of a received byte
// stream and passes out payload bytes, disconnect notices and error items.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | tdata[7:0] stream_byte
//  m_*      | out       | tdata data_byte, error_code; tuser kind; tlast last
//  cfg_*    | in        | index 0 local_ref, index 1 remote_ref
//
//  One byte per cycle while s_tready is high: the parser classifies each byte
//  in the cycle it is accepted and writes any result into a QUEUE_DEPTH-entry
//  queue. s_tready drops only while the queue is full; results leave one per
//  cycle while m_tready is high. Reset puts the parser back to waiting for a
//  TPKT version byte and empties the queue; configuration registers reset to zero.
// ----------------------------------------------------------------------------
module transport_data_tpdu_deframer
    import tpdu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] stream_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] data_byte, [11:8] error_code, [15:12] zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast
);

    logic         queue_full;
    logic         byte_accept;
    logic         res_valid;
    tpdu_result_t res;
    tpdu_result_t head;

    assign s_tready    = !queue_full;
    assign byte_accept = s_tvalid && s_tready;

    // header parser
    tpdu_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_valid  (byte_accept),
        .stream_byte (s_tdata),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result queue
    tpdu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .full       (queue_full),
        .head_valid (m_tvalid),
        .pop        (m_tready),
        .head_data  (head)
    );

    // output packing
    assign m_tdata = {4'd0, head.error_code, head.data_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

// ===== hw/rtl/tpdu_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpdu_parser
// Front end: walks the TPKT and transport headers one byte per item and
// classifies each byte into zero or one result item.
// ----------------------------------------------------------------------------
module tpdu_parser
    import tpdu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         byte_valid,
    input  logic [7:0]   stream_byte,
    output logic         res_valid,
    output tpdu_result_t res
);

    logic [15:0] local_ref_reg;
    logic [15:0] remote_ref_reg;
    tpdu_phase_t phase_reg, phase_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] payload_left_reg, payload_left_next;
    logic        li_dr_reg, li_dr_next;
    logic        eot_seen_reg, eot_seen_next;
    logic [7:0]  ref_hi_reg, ref_hi_next;
    logic [15:0] packet_len;
    logic [15:0] ref_word;

    assign packet_len = {len_hi_reg, stream_byte};
    assign ref_word   = {ref_hi_reg, stream_byte};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ref_reg  <= '0;
            remote_ref_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOCAL_REF:  local_ref_reg  <= cfg_data;
                CFG_REMOTE_REF: remote_ref_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // per-byte header walk
    always_comb
    begin
        phase_next        = phase_reg;
        len_hi_next       = len_hi_reg;
        payload_left_next = payload_left_reg;
        li_dr_next        = li_dr_reg;
        eot_seen_next     = eot_seen_reg;
        ref_hi_next       = ref_hi_reg;
        res_valid         = 1'b0;
        res.kind          = KIND_ERROR;
        res.data_byte     = 8'd0;
        res.last          = 1'b0;
        res.error_code    = ERR_NONE;
        case (phase_reg)
            PH_RSV:
            begin
                if (stream_byte != TPKT_RESERVED)
                begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_RESERVED;
                    phase_next     = PH_VER;
                end
                else
                    phase_next = PH_LENHI;
            end
            PH_LENHI:
            begin
                len_hi_next = stream_byte;
                phase_next  = PH_LENLO;
            end
            PH_LENLO:
            begin
                payload_left_next = packet_len - HEADER_LEN;
                if (packet_len <= HEADER_LEN)
                begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_SHORT;
                    phase_next     = PH_VER;
                end
                else
                    phase_next = PH_LI;
            end
            PH_LI:
            begin
                li_dr_next = (stream_byte == LI_DR);
                if (stream_byte != LI_DT && stream_byte != LI_DR)
                begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_LI;
                    phase_next     = PH_VER;
                end
                else
                    phase_next = PH_CODE;
            end
            PH_CODE:
            begin
                phase_next = PH_VER;
                if (stream_byte == CODE_DT && !li_dr_reg)
                    phase_next = PH_EOT;
                else if (stream_byte == CODE_DR && li_dr_reg)
                    phase_next = PH_R1HI;
                else
                begin
                    res_valid = 1'b1;
                    if (stream_byte == CODE_DT || stream_byte == CODE_DR)
                        res.error_code = ERR_LI;
                    else if (stream_byte == CODE_ER)
                        res.error_code = ERR_ER_TPDU;
                    else
                        res.error_code = ERR_UNKNOWN;
                end
            end
            PH_EOT:
            begin
                eot_seen_next = (stream_byte == EOT_SET);
                if (stream_byte != EOT_CLEAR && stream_byte != EOT_SET)
                begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_EOT;
                    phase_next     = PH_VER;
                end
                else if (payload_left_reg == 16'd0)
                    phase_next = PH_VER;
                else
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                res_valid         = 1'b1;
                res.kind          = KIND_DATA;
                res.data_byte     = stream_byte;
                res.last          = (payload_left_reg == 16'd1) && eot_seen_reg;
                payload_left_next = payload_left_reg - 16'd1;
                if (payload_left_reg == 16'd1)
                    phase_next = PH_VER;
            end
            PH_R1HI:
            begin
                ref_hi_next = stream_byte;
                phase_next  = PH_R1LO;
            end
            PH_R1LO:
            begin
                if (ref_word != local_ref_reg)
                begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_SRC_REF;
                    phase_next     = PH_VER;
                end
                else
                    phase_next = PH_R2HI;
            end
            PH_R2HI:
            begin
                ref_hi_next = stream_byte;
                phase_next  = PH_R2LO;
            end
            PH_R2LO:
            begin
                if (ref_word != remote_ref_reg)
                begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_DST_REF;
                    phase_next     = PH_VER;
                end
                else
                    phase_next = PH_REASON;
            end
            PH_REASON:
            begin
                res_valid  = 1'b1;
                phase_next = PH_VER;
                if (stream_byte > REASON_MAX)
                    res.error_code = ERR_REASON;
                else
                    res.kind = KIND_DISC;
            end
            default:
            begin
                // awaiting the version byte
                if (stream_byte != TPKT_VERSION)
                begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_VERSION;
                    phase_next     = PH_VER;
                end
                else
                    phase_next = PH_RSV;
            end
        endcase
        if (!byte_valid)
            res_valid = 1'b0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_VER;
            len_hi_reg       <= '0;
            payload_left_reg <= '0;
            li_dr_reg        <= 1'b0;
            eot_seen_reg     <= 1'b0;
            ref_hi_reg       <= '0;
        end
        else if (byte_valid)
        begin
            phase_reg        <= phase_next;
            len_hi_reg       <= len_hi_next;
            payload_left_reg <= payload_left_next;
            li_dr_reg        <= li_dr_next;
            eot_seen_reg     <= eot_seen_next;
            ref_hi_reg       <= ref_hi_next;
        end
    end

endmodule

// ===== hw/rtl/tpdu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpdu_queue
// Back end: short result queue whose head drives the output stream, so the
// parser and the consumer stall independently.
// ----------------------------------------------------------------------------
module tpdu_queue
    import tpdu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  tpdu_result_t push_data,
    output logic         full,
    output logic         head_valid,
    input  logic         pop,
    output tpdu_result_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tpdu_result_t     store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_data  = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== dv/transport_data_tpdu_deframer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transport_data_tpdu_deframer_test
// Self-checking bench for the TPKT / transport TPDU deframer. Byte frames
// (data, disconnect, error, broken and noise) are streamed in with random
// gaps while the result side stalls at random. A parser model inside the
// bench predicts every payload, disconnect and error item, and each output
// item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module transport_data_tpdu_deframer_test;
    import tpdu_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_BYTES  = 180;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_LOCAL_REF;
    logic [15:0] cfg_data  = 16'h0000;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;    // [7:0] stream_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;              // [7:0] data_byte, [11:8] error_code, [15:12] zero
    logic [1:0]  m_tuser;              // [1:0] kind
    logic        m_tlast;

    // parser model state and register copies
    tpdu_phase_t prs_phase   = PH_VER;
    logic [15:0] prs_len     = 16'h0000;
    logic [15:0] prs_left    = 16'h0000;
    logic [7:0]  prs_li      = 8'h00;
    logic        prs_eot     = 1'b0;
    logic [15:0] prs_ref     = 16'h0000;
    logic [15:0] local_ref_q = 16'h0000;
    logic [15:0] remote_ref_q = 16'h0000;

    tpdu_result_t pending_results[$];
    logic [7:0]   frame_bytes[$];

    int  errors      = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  rx_took     = 1'b0;
    bit  tx_eager    = 1'b0;
    bit  rx_eager    = 1'b0;

    transport_data_tpdu_deframer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always #2 clk = ~clk;

    // parser model: one stream byte in, at most one result out
    function automatic bit parse_byte(input logic [7:0] b, output tpdu_result_t res);
        bit         hit;
        logic [3:0] err;
        hit = 1'b0;
        err = ERR_NONE;
        res = '0;
        case (prs_phase)
            PH_RSV:
            begin
                if (b != TPKT_RESERVED) err = ERR_RESERVED;
                else prs_phase = PH_LENHI;
            end
            PH_LENHI:
            begin
                prs_len   = {b, 8'h00};
                prs_phase = PH_LENLO;
            end
            PH_LENLO:
            begin
                prs_len[7:0] = b;
                if (prs_len <= HEADER_LEN) err = ERR_SHORT;
                else prs_phase = PH_LI;
            end
            PH_LI:
            begin
                prs_li = b;
                if (b != LI_DT && b != LI_DR) err = ERR_LI;
                else prs_phase = PH_CODE;
            end
            PH_CODE:
            begin
                if (b == CODE_DT)
                begin
                    if (prs_li != LI_DT) err = ERR_LI;
                    else prs_phase = PH_EOT;
                end
                else if (b == CODE_DR)
                begin
                    if (prs_li != LI_DR) err = ERR_LI;
                    else prs_phase = PH_R1HI;
                end
                else if (b == CODE_ER) err = ERR_ER_TPDU;
                else err = ERR_UNKNOWN;
            end
            PH_EOT:
            begin
                if (b != EOT_CLEAR && b != EOT_SET) err = ERR_EOT;
                else
                begin
                    prs_eot   = (b == EOT_SET);
                    prs_left  = prs_len - HEADER_LEN;
                    prs_phase = (prs_left == 16'h0000) ? PH_VER : PH_DATA;
                end
            end
            PH_DATA:
            begin
                hit           = 1'b1;
                res.kind      = KIND_DATA;
                res.data_byte = b;
                res.last      = (prs_left == 16'd1) && prs_eot;
                prs_left      = prs_left - 16'd1;
                if (prs_left == 16'h0000) prs_phase = PH_VER;
            end
            PH_R1HI:
            begin
                prs_ref   = {b, 8'h00};
                prs_phase = PH_R1LO;
            end
            PH_R2HI:
            begin
                prs_ref   = {b, 8'h00};
                prs_phase = PH_R2LO;
            end
            PH_R1LO:
            begin
                prs_ref[7:0] = b;
                if (prs_ref != local_ref_q) err = ERR_SRC_REF;
                else prs_phase = PH_R2HI;
            end
            PH_R2LO:
            begin
                prs_ref[7:0] = b;
                if (prs_ref != remote_ref_q) err = ERR_DST_REF;
                else prs_phase = PH_REASON;
            end
            PH_REASON:
            begin
                if (b > REASON_MAX) err = ERR_REASON;
                else
                begin
                    hit       = 1'b1;
                    res.kind  = KIND_DISC;
                    prs_phase = PH_VER;
                end
            end
            default:
            begin
                if (b != TPKT_VERSION) err = ERR_VERSION;
                else prs_phase = PH_RSV;
            end
        endcase
        // any failed check gives one error item and a fresh header hunt
        if (err != ERR_NONE)
        begin
            hit            = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = err;
            prs_phase      = PH_VER;
        end
        return hit;
    endfunction

    // input and output monitor: predicts on every accepted byte, checks every result
    always @(posedge clk)
    begin : monitor
        tpdu_result_t want;
        tpdu_result_t seen;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (s_tvalid && s_tready)
            begin
                moved = 1'b1;
                if (parse_byte(s_tdata, want)) pending_results = {pending_results, want};
            end
            rx_took = m_tvalid && m_tready;
            if (rx_took)
            begin
                moved           = 1'b1;
                seen.kind       = m_tuser;
                seen.data_byte  = m_tdata[7:0];
                seen.last       = m_tlast;
                seen.error_code = m_tdata[11:8];
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected item: kind %0d byte %02h last %0d err %0d",
                             $time, seen.kind, seen.data_byte, seen.last, seen.error_code);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen !== want || m_tdata[15:12] !== 4'h0)
                    begin
                        errors++;
                        $display("%0t ns: mismatch: expected kind %0d byte %02h last %0d err %0d",
                                 $time, want.kind, want.data_byte, want.last, want.error_code);
                        $display("%0t ns:           actual kind %0d byte %02h last %0d err %0d pad %h",
                                 $time, seen.kind, seen.data_byte, seen.last, seen.error_code,
                                 m_tdata[15:12]);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // result side back-pressure, a fresh stall drawn after each item taken
    always @(negedge clk)
    begin
        if (rx_took) stall_left = rx_eager ? 0 : $urandom_range(0, 14);
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    // send one stream byte after a random gap, returns at the accepting edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_frame_bytes();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    // append one byte to the frame being built
    task automatic add_byte(input logic [7:0] b);
        frame_bytes = {frame_bytes, b};
    endtask

    // stop sending and wait until every predicted item has come out
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_ref(input logic idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_LOCAL_REF) local_ref_q = value;
        else remote_ref_q = value;
    endtask

    task automatic put_tpkt(input logic [15:0] len);
        add_byte(TPKT_VERSION);
        add_byte(TPKT_RESERVED);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
    endtask

    // data header only; the caller appends the payload
    task automatic put_dt_head(input int n, input logic [7:0] eot);
        put_tpkt(16'(n) + HEADER_LEN);
        add_byte(LI_DT);
        add_byte(CODE_DT);
        add_byte(eot);
    endtask

    task automatic put_dr(input logic [15:0] len, input logic [15:0] src,
                          input logic [15:0] dst, input logic [7:0] reason);
        put_tpkt(len);
        add_byte(LI_DR);
        add_byte(CODE_DR);
        add_byte(src[15:8]);
        add_byte(src[7:0]);
        add_byte(dst[15:8]);
        add_byte(dst[7:0]);
        add_byte(reason);
    endtask

    // data tpdus: eot set and clear, single byte payload, byte extremes
    task automatic test_data_tpdus();
        put_dt_head(3, EOT_SET);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h5A);
        put_dt_head(1, EOT_CLEAR);
        add_byte(8'hA5);
        put_dt_head(1, EOT_SET);
        add_byte(8'hFF);
        send_frame_bytes();
        settle();
    endtask

    // disconnect requests against reset, extreme and mixed references
    task automatic test_disconnects();
        put_dr(16'd8, 16'h0000, 16'h0000, 8'd0);
        send_frame_bytes();
        settle();
        write_ref(CFG_LOCAL_REF, 16'hFFFF);
        write_ref(CFG_REMOTE_REF, 16'hFFFF);
        // longest length field; trailing bytes are parsed as a new header
        put_dr(16'hFFFF, 16'hFFFF, 16'hFFFF, REASON_MAX);
        add_byte(8'hAA);
        send_frame_bytes();
        settle();
        write_ref(CFG_LOCAL_REF, 16'h1234);
        write_ref(CFG_REMOTE_REF, 16'hABCD);
        put_dr(16'd12, 16'h1235, 16'hABCD, 8'd0);
        put_dr(16'd12, 16'h1234, 16'h2BCD, 8'd0);
        put_dr(16'd12, 16'h1234, 16'hABCD, 8'd5);
        put_dr(16'd12, 16'h1234, 16'hABCD, 8'hFF);
        put_dr(16'd12, 16'h1234, 16'hABCD, 8'd3);
        send_frame_bytes();
        settle();
    endtask

    // header faults: version, reserved, length, li, code and eot checks
    task automatic test_header_errors();
        frame_bytes = '{8'h00, 8'hFF};
        add_byte(TPKT_VERSION);
        add_byte(8'hFF);
        put_tpkt(16'd7);
        put_tpkt(16'd0);
        // length indicator wrong at the li byte
        put_tpkt(16'd12);
        add_byte(8'h00);
        put_tpkt(16'd12);
        add_byte(8'hFF);
        // length indicator not matching the code
        put_tpkt(16'd12);
        add_byte(LI_DR);
        add_byte(CODE_DT);
        put_tpkt(16'd12);
        add_byte(LI_DT);
        add_byte(CODE_DR);
        // error tpdu under either li, then an unknown code
        put_tpkt(16'd12);
        add_byte(LI_DT);
        add_byte(CODE_ER);
        put_tpkt(16'd12);
        add_byte(LI_DR);
        add_byte(CODE_ER);
        put_tpkt(16'd12);
        add_byte(LI_DT);
        add_byte(8'h55);
        // bad eot byte
        put_dt_head(2, 8'h40);
        send_frame_bytes();
        settle();
    endtask

    // one random frame: mostly well formed, some broken, some noise
    task automatic build_random_frame();
        int sel;
        int n;
        int p;
        sel = $urandom_range(0, 99);
        if (sel < 90)
        begin
            if (sel < 50 || (sel >= 70 && sel < 80))
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
                put_dt_head(n, $urandom_range(0, 1) ? EOT_SET : EOT_CLEAR);
                repeat (n) add_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                put_dr(16'($urandom_range(8, 65535)), local_ref_q, remote_ref_q,
                       ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 4))
                                                   : 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
            end
            // broken frame: one byte overwritten; a hit on the length high byte keeps the length short
            if (sel >= 70)
            begin
                p = $urandom_range(0, frame_bytes.size() - 1);
                if (p == 2) frame_bytes[p] = 8'($urandom_range(0, 1));
                else frame_bytes[p] = 8'($urandom_range(0, 255));
            end
        end
        else
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
    endtask

    // random traffic under several reference settings
    task automatic test_random_traffic();
        int  setting;
        int  sent;
        bit  paused;
        paused = 1'b0;
        for (setting = 0; setting < 4; setting++)
        begin
            case (setting)
                0:
                begin
                    write_ref(CFG_LOCAL_REF, 16'($urandom_range(0, 65535)));
                    write_ref(CFG_REMOTE_REF, 16'($urandom_range(0, 65535)));
                end
                1:
                begin
                    write_ref(CFG_LOCAL_REF, 16'h0000);
                    write_ref(CFG_REMOTE_REF, 16'hFFFF);
                end
                2:
                begin
                    write_ref(CFG_LOCAL_REF, 16'hFFFF);
                    write_ref(CFG_REMOTE_REF, 16'h0000);
                end
                default:
                begin
                    write_ref(CFG_LOCAL_REF, 16'($urandom_range(0, 65535)));
                    write_ref(CFG_REMOTE_REF, 16'($urandom_range(0, 65535)));
                end
            endcase
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                tx_eager = ($urandom_range(0, 7) == 0);
                rx_eager = ($urandom_range(0, 7) == 0);
                build_random_frame();
                sent += frame_bytes.size();
                send_frame_bytes();
                // hold the sender until every result is out
                if (setting == 1 && !paused && sent > PHASE_BYTES / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
            settle();
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_data_tpdus();
        test_disconnects();
        test_header_errors();
        test_random_traffic();
        settle();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
